@@ sv/ppgp_pkg.sv @@
// ----------------------------------------------------------------------------
// ppgp_pkg
// Shared types and constants of the power gate planner: event codes,
// register indexes, the transfer payloads and the plan entry layout.
// ----------------------------------------------------------------------------
package ppgp_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 16;
   localparam int OP_ID_BITS_DEFAULT  = 16;

   localparam logic [31:0] BOOT_MASK_RESET = 32'd1;

   // event codes
   localparam logic [1:0] OP_LOAD        = 2'd0;
   localparam logic [1:0] OP_FRAME_START = 2'd1;
   localparam logic [1:0] OP_COMPLETE    = 2'd2;
   localparam logic [1:0] OP_FRAME_END   = 2'd3;

   // register indexes
   localparam logic REG_PLAN_LENGTH = 1'b0;
   localparam logic REG_BOOT_MASK   = 1'b1;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  entry_index;
      logic [31:0] entry_domain;
      logic [15:0] entry_first_op;
      logic [15:0] entry_last_op;
      logic        entry_always_on;
      logic [15:0] completed_op;
   } req_item_type;

   typedef struct packed {
      logic [31:0] active_mask;
      logic [31:0] enable_count;
      logic [31:0] disable_count;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] domain;
      logic [15:0] first_op;
      logic [15:0] last_op;
      logic        keep_on;
   } plan_entry_type;

   typedef struct packed {
      logic        boot_load;
      logic [31:0] boot_value;
   } cfg_ctrl_type;

endpackage

@@ sv/ppgp_plan_mem.sv @@
// ----------------------------------------------------------------------------
// ppgp_plan_mem
// Plan table: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ppgp_plan_mem
   import ppgp_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT,
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  plan_entry_type   wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output plan_entry_type   rd_data
);

   plan_entry_type plan_ram [MAX_ENTRIES];
   plan_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         plan_ram[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= plan_ram[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ppgp_seq.sv @@
// ----------------------------------------------------------------------------
// ppgp_seq
// Event sequencer: loads plan entries, walks the plan one entry a cycle
// and updates the active mask and the enable and disable counters.
// ----------------------------------------------------------------------------
module ppgp_seq
   import ppgp_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT,
   parameter int OP_ID_BITS  = OP_ID_BITS_DEFAULT,
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_item_type     req_item,
   input  logic [4:0]       plan_length,
   input  cfg_ctrl_type     cfg_ctrl,
   output logic             mem_wr_en,
   output logic [IDX_W-1:0] mem_wr_addr,
   output plan_entry_type   mem_wr_data,
   output logic [IDX_W-1:0] mem_rd_addr,
   input  plan_entry_type   mem_rd_data,
   output logic             rsp_valid,
   output rsp_item_type     rsp_item
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_RESP = 3'b100
   } seq_state_type;

   localparam logic [15:0] OP_MASK =
      (OP_ID_BITS >= 16) ? 16'hFFFF : 16'((33'd1 << OP_ID_BITS) - 33'd1);

   seq_state_type state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [15:0]      done_ff, done_in;
   logic [16:0]      next_ff, next_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] last_ff, last_in;
   logic [31:0]      mask_ff, mask_in;
   logic [31:0]      en_cnt_ff, en_cnt_in;
   logic [31:0]      dis_cnt_ff, dis_cnt_in;

   logic             accept;
   logic [CNT_W-1:0] walk_len;
   logic             slot_ok;
   logic             gate_on;
   logic             gate_off;
   logic [15:0]      done_masked;

   assign accept      = start && (state_ff == ST_IDLE);
   assign busy        = (state_ff != ST_IDLE);
   assign done_masked = req_item.completed_op & OP_MASK;
   assign slot_ok     = (9'(req_item.entry_index) < 9'(MAX_ENTRIES));

   always_comb begin
      if (9'(plan_length) > 9'(MAX_ENTRIES)) begin
         walk_len = CNT_W'(MAX_ENTRIES);
      end else begin
         walk_len = CNT_W'(plan_length);
      end
   end

   // plan entry write on an accepted load
   assign mem_wr_en   = accept && (req_item.op == OP_LOAD) && slot_ok;
   assign mem_wr_addr = IDX_W'(req_item.entry_index);
   always_comb begin
      mem_wr_data.domain   = req_item.entry_domain;
      mem_wr_data.first_op = req_item.entry_first_op & OP_MASK;
      mem_wr_data.last_op  = req_item.entry_last_op & OP_MASK;
      mem_wr_data.keep_on  = req_item.entry_always_on;
   end

   // prefetch the next entry while the current one is applied
   always_comb begin
      if ((state_ff == ST_WALK) && (idx_ff != last_ff)) begin
         mem_rd_addr = IDX_W'(idx_ff + CNT_W'(1));
      end else begin
         mem_rd_addr = '0;
      end
   end

   always_comb begin
      gate_on  = 1'b0;
      gate_off = 1'b0;
      case (op_ff)
         OP_FRAME_START: begin
            gate_on = (mem_rd_data.first_op == 16'd0) || mem_rd_data.keep_on;
         end
         OP_COMPLETE: begin
            gate_off = !mem_rd_data.keep_on && (mem_rd_data.last_op == done_ff);
            gate_on  = !mem_rd_data.keep_on && ({1'b0, mem_rd_data.first_op} == next_ff);
         end
         OP_FRAME_END: begin
            gate_off = !mem_rd_data.keep_on;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      done_in    = done_ff;
      next_in    = next_ff;
      idx_in     = idx_ff;
      last_in    = last_ff;
      mask_in    = mask_ff;
      en_cnt_in  = en_cnt_ff;
      dis_cnt_in = dis_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_item.op;
               done_in = done_masked;
               next_in = {1'b0, done_masked} + 17'd1;
               idx_in  = '0;
               last_in = walk_len - CNT_W'(1);
               if ((req_item.op == OP_LOAD) || (walk_len == '0)) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // disable first, then enable, as one step per entry
            mask_in = mask_ff;
            if (gate_off) begin
               mask_in = mask_in & ~mem_rd_data.domain;
            end
            if (gate_on) begin
               mask_in = mask_in | mem_rd_data.domain;
            end
            en_cnt_in  = en_cnt_ff + 32'(gate_on);
            dis_cnt_in = dis_cnt_ff + 32'(gate_off);
            idx_in     = idx_ff + CNT_W'(1);
            if (idx_ff == last_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cfg_ctrl.boot_load) begin
         mask_in = cfg_ctrl.boot_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mask_ff    <= BOOT_MASK_RESET;
         en_cnt_ff  <= '0;
         dis_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         mask_ff    <= mask_in;
         en_cnt_ff  <= en_cnt_in;
         dis_cnt_ff <= dis_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      done_ff <= done_in;
      next_ff <= next_in;
      idx_ff  <= idx_in;
      last_ff <= last_in;
   end

   assign rsp_valid              = (state_ff == ST_RESP);
   assign rsp_item.active_mask   = mask_ff;
   assign rsp_item.enable_count  = en_cnt_ff;
   assign rsp_item.disable_count = dis_cnt_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted event did not raise busy");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (idx_ff <= last_ff))
      else $error("plan walk ran past its last entry");

   a_start_no_disable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) && (op_ff == OP_FRAME_START) |=> $stable(dis_cnt_ff))
      else $error("frame start counted a disable");

   a_end_no_enable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) && (op_ff == OP_FRAME_END) |=> $stable(en_cnt_ff))
      else $error("frame end counted an enable");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

endmodule

@@ sv/phase_aware_power_gate_planner.sv @@
// ----------------------------------------------------------------------------
// phase_aware_power_gate_planner
// Power gate planner: plan table of domain entries walked on frame and op
// events, with the active domain mask and enable and disable counters.
//
// Usage:
//   An event transfer is taken at a rising edge with start high and busy
//   low; req_item carries the event code and its fields. Each event gives
//   exactly one result on rsp_item, shown for one cycle with rsp_valid high.
//   The receiver cannot stall the result.
//   A load entry writes one plan slot; its result follows in the next
//   cycle. Frame start, op complete and frame end walk the plan from
//   slot 0, one entry a cycle through the plan memory read port, over
//   plan_length entries capped at MAX_ENTRIES; a zero length skips the
//   walk and gives the result directly. busy stays high until
//   the result cycle has ended, so one event is in flight at a time.
//   The APB port holds plan_length and boot_mask; a boot_mask write also
//   reloads the active mask. Write registers only while busy is low.
//   Reset clears the counters, loads the active mask with 1 and leaves the
//   plan table unwritten: slots must be loaded before they are walked.
// ----------------------------------------------------------------------------
module phase_aware_power_gate_planner
   import ppgp_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT,
   parameter int OP_ID_BITS  = OP_ID_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   logic [4:0]       plan_length_ff;
   logic [31:0]      boot_mask_ff;
   logic             csr_wr;
   logic             csr_idx;
   cfg_ctrl_type     cfg_ctrl;

   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   plan_entry_type   mem_wr_data;
   logic [IDX_W-1:0] mem_rd_addr;
   plan_entry_type   mem_rd_data;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         plan_length_ff <= '0;
         boot_mask_ff   <= BOOT_MASK_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_PLAN_LENGTH: plan_length_ff <= pwdata[4:0];
            REG_BOOT_MASK:   boot_mask_ff   <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_PLAN_LENGTH: prdata = {27'd0, plan_length_ff};
         REG_BOOT_MASK:   prdata = boot_mask_ff;
         default:         prdata = '0;
      endcase
   end

   assign cfg_ctrl.boot_load  = csr_wr && (csr_idx == REG_BOOT_MASK);
   assign cfg_ctrl.boot_value = pwdata;

   ppgp_plan_mem #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_plan_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ppgp_seq #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .OP_ID_BITS  (OP_ID_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .plan_length (plan_length_ff),
      .cfg_ctrl    (cfg_ctrl),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

endmodule

@@ tb/phase_aware_power_gate_planner_test.sv @@
// ----------------------------------------------------------------------------
// phase_aware_power_gate_planner_test
// Self-checking bench for the power gate planner. A short directed table
// loads every plan slot and hits the register extremes. Then random phases
// reprogram the plan length and boot mask and run frames of well-formed
// start / op complete / end sequences mixed with noise events. Each result
// is compared with a local model of the plan table, mask and counters.
// ----------------------------------------------------------------------------
module phase_aware_power_gate_planner_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ppgp_pkg::*;

   localparam int SLOTS        = MAX_ENTRIES_DEFAULT;
   localparam int STALL_LIMIT  = 1000;
   localparam int TAIL_CYCLES  = SLOTS + 4;
   localparam int RANDOM_ITEMS = 1150;

   localparam logic [2:0] ADDR_PLAN_LENGTH = {REG_PLAN_LENGTH, 2'b00};
   localparam logic [2:0] ADDR_BOOT_MASK   = {REG_BOOT_MASK, 2'b00};

   localparam rsp_item_type BOOT_STATUS = '{BOOT_MASK_RESET, 32'd0, 32'd0};

   typedef struct {
      bit           is_write;
      logic [2:0]   addr;
      logic [31:0]  wdata;
      req_item_type ev;
      bit           known;
      rsp_item_type status;
   } plan_step_type;

   typedef struct {
      bit           known;
      rsp_item_type status;
   } pinned_type;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         psel;
   logic         penable;
   logic         pwrite;
   logic [2:0]   paddr;
   logic [31:0]  pwdata;
   logic [31:0]  prdata;
   logic         pready;

   phase_aware_power_gate_planner dut (.*);

   // local copy of the planner state
   plan_entry_type gate_plan [SLOTS];
   logic [4:0]     plan_len_reg;
   logic [31:0]    gated_mask;
   logic [31:0]    enable_total;
   logic [31:0]    disable_total;

   rsp_item_type awaited_status [$];
   pinned_type   pinned_status [$];

   int fail_count   = 0;
   int quiet_cycles = 0;
   int events_sent  = 0;
   bit no_idle      = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic advance_power_plan(input req_item_type ev, output rsp_item_type status);
      int          walk;
      int          i;
      logic [16:0] next_op;
      walk    = (plan_len_reg > SLOTS) ? SLOTS : plan_len_reg;
      next_op = {1'b0, ev.completed_op} + 17'd1;
      case (ev.op)
         OP_LOAD: begin
            gate_plan[ev.entry_index] = '{ev.entry_domain, ev.entry_first_op,
                                          ev.entry_last_op, ev.entry_always_on};
         end
         OP_FRAME_START: begin
            for (i = 0; i < walk; i++) begin
               if (gate_plan[i].first_op == '0 || gate_plan[i].keep_on) begin
                  enable_total++;
                  gated_mask |= gate_plan[i].domain;
               end
            end
         end
         OP_COMPLETE: begin
            // disable on a last-op match first, then enable on the next op
            for (i = 0; i < walk; i++) begin
               if (!gate_plan[i].keep_on) begin
                  if (gate_plan[i].last_op == ev.completed_op) begin
                     disable_total++;
                     gated_mask &= ~gate_plan[i].domain;
                  end
                  if ({1'b0, gate_plan[i].first_op} == next_op) begin
                     enable_total++;
                     gated_mask |= gate_plan[i].domain;
                  end
               end
            end
         end
         default: begin
            for (i = 0; i < walk; i++) begin
               if (!gate_plan[i].keep_on) begin
                  disable_total++;
                  gated_mask &= ~gate_plan[i].domain;
               end
            end
         end
      endcase
      status = '{gated_mask, enable_total, disable_total};
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type predicted;
      pinned_type   hint;
      bit           moved;
      moved = 0;
      if (reset) begin
         plan_len_reg  = '0;
         gated_mask    = BOOT_MASK_RESET;
         enable_total  = '0;
         disable_total = '0;
         quiet_cycles  = 0;
      end else begin
         if (rsp_valid) begin
            moved = 1;
            if (awaited_status.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_item);
               fail_count++;
            end else begin
               want = awaited_status.pop_front();
               check_field("active_mask", want.active_mask, rsp_item.active_mask);
               check_field("enable_count", want.enable_count, rsp_item.enable_count);
               check_field("disable_count", want.disable_count, rsp_item.disable_count);
            end
         end
         if (start && !busy) begin
            moved = 1;
            advance_power_plan(req_item, predicted);
            hint.known  = 1'b0;
            hint.status = '0;
            if (pinned_status.size() != 0) begin
               hint = pinned_status.pop_front();
            end
            awaited_status.push_back(hint.known ? hint.status : predicted);
         end
         if (psel && penable && pready) begin
            moved = 1;
            if (pwrite && paddr == ADDR_PLAN_LENGTH) begin
               plan_len_reg = pwdata[4:0];
            end else if (pwrite && paddr == ADDR_BOOT_MASK) begin
               // a boot mask write reloads the active mask at once
               gated_mask = pwdata;
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   initial begin
      @(negedge clock);
      while (quiet_cycles < STALL_LIMIT) @(negedge clock);
      $display("== FAIL ==");
      $finish;
   end

   // all driving tasks start and end just after a falling edge
   task automatic send_event(input req_item_type ev, input bit known = 0,
                             input rsp_item_type status = '0);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      pinned_status.push_back('{known, status});
      req_item = ev;
      start    = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      events_sent++;
   endtask

   task automatic drain_events();
      start = 1'b0;
      while (awaited_status.size() != 0 || busy) @(negedge clock);
   endtask

   // write a register, then read it back
   task automatic csr_access(input logic [2:0] addr, input logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] want;
      want    = (addr == ADDR_PLAN_LENGTH) ? {27'd0, value[4:0]} : value;
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if (readback !== want) begin
         $display("%0t: register %0d readback mismatch, expected %h, actual %h",
                  $time, addr, want, readback);
         fail_count++;
      end
   endtask

   function automatic req_item_type make_event(input logic [1:0] op, input logic [3:0] idx,
                                               input logic [31:0] dom,
                                               input logic [15:0] first_op,
                                               input logic [15:0] last_op,
                                               input logic aon, input logic [15:0] done);
      req_item_type ev;
      ev = '{op, idx, dom, first_op, last_op, aon, done};
      return ev;
   endfunction

   function automatic plan_step_type event_step(input logic [1:0] op, input logic [3:0] idx,
                                                input logic [31:0] dom,
                                                input logic [15:0] first_op,
                                                input logic [15:0] last_op,
                                                input logic aon, input logic [15:0] done);
      plan_step_type s;
      s          = '{default: '0};
      s.ev       = make_event(op, idx, dom, first_op, last_op, aon, done);
      return s;
   endfunction

   function automatic plan_step_type write_step(input logic [2:0] addr,
                                                input logic [31:0] value);
      plan_step_type s;
      s          = '{default: '0};
      s.is_write = 1'b1;
      s.addr     = addr;
      s.wdata    = value;
      return s;
   endfunction

   function automatic plan_step_type at_boot(input plan_step_type s);
      s.known  = 1'b1;
      s.status = BOOT_STATUS;
      return s;
   endfunction

   function automatic req_item_type noise_event();
      return make_event(2'($urandom_range(0, 3)), 4'($urandom_range(0, SLOTS - 1)),
                        $urandom, 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                        16'($urandom_range(0, 65535)));
   endfunction

   // reload a few slots with short op ranges, then run one frame through
   task automatic run_frame();
      int          loads;
      int          last_id;
      int          id;
      logic [15:0] first_op;
      logic [31:0] dom;
      loads = $urandom_range(0, 4);
      repeat (loads) begin
         first_op = 16'($urandom_range(0, 7));
         dom      = $urandom_range(0, 1) ? $urandom : (32'd1 << $urandom_range(0, 31));
         send_event(make_event(OP_LOAD, 4'($urandom_range(0, SLOTS - 1)), dom, first_op,
                               16'(first_op + $urandom_range(0, 3)),
                               $urandom_range(0, 7) == 0, 16'($urandom_range(0, 65535))));
      end
      send_event(make_event(OP_FRAME_START, 4'($urandom_range(0, SLOTS - 1)), $urandom,
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535))));
      last_id = $urandom_range(2, 10);
      for (id = 0; id <= last_id; id++) begin
         send_event(make_event(OP_COMPLETE, 4'($urandom_range(0, SLOTS - 1)), $urandom,
                               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                               1'($urandom_range(0, 1)), 16'(id)));
      end
      if ($urandom_range(0, 7) != 0) begin
         send_event(make_event(OP_FRAME_END, 0, 0, 0, 0, 0, 0));
      end
   endtask

   initial begin
      plan_step_type directed_steps [$];
      plan_step_type step;
      logic [31:0]   dom;
      logic [15:0]   first_op;
      logic [15:0]   last_op;
      logic          aon;
      logic [31:0]   boot_value;
      int            i;
      int            phase_start;
      int            phase_goal;
      int            random_base;

      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty walks, then load every slot before any walk reads one
      directed_steps.push_back(at_boot(event_step(OP_FRAME_START, 0, 0, 0, 0, 0, 0)));
      directed_steps.push_back(at_boot(event_step(OP_COMPLETE, 0, 0, 0, 0, 0, 16'hFFFF)));
      directed_steps.push_back(at_boot(event_step(OP_FRAME_END, 0, 0, 0, 0, 0, 0)));
      for (i = 0; i < SLOTS; i++) begin
         case (i)
            0: begin
               dom = 32'hFFFF_FFFF; first_op = 16'h0000; last_op = 16'hFFFF; aon = 1'b0;
            end
            1: begin
               dom = 32'h0000_0000; first_op = 16'hFFFF; last_op = 16'h0000; aon = 1'b1;
            end
            default: begin
               dom      = 32'd1 << i;
               first_op = 16'(i % 6);
               last_op  = 16'((i % 6) + (i % 3));
               aon      = (i % 5) == 0;
            end
         endcase
         directed_steps.push_back(at_boot(event_step(OP_LOAD, 4'(i), dom, first_op, last_op,
                                                     aon, 16'hFFFF)));
      end
      directed_steps.push_back(write_step(ADDR_PLAN_LENGTH, SLOTS));
      directed_steps.push_back(event_step(OP_FRAME_START, 0, 0, 0, 0, 0, 0));
      directed_steps.push_back(event_step(OP_COMPLETE, 0, 0, 0, 0, 0, 16'h0000));
      // largest op id: the next op would be out of range, so nothing enables
      directed_steps.push_back(event_step(OP_COMPLETE, 0, 0, 0, 0, 0, 16'hFFFF));
      directed_steps.push_back(event_step(OP_FRAME_END, 0, 0, 0, 0, 0, 0));
      // plan length above the table size walks the whole table
      directed_steps.push_back(write_step(ADDR_PLAN_LENGTH, 31));
      directed_steps.push_back(event_step(OP_FRAME_START, 0, 0, 0, 0, 0, 0));
      directed_steps.push_back(write_step(ADDR_BOOT_MASK, 32'hFFFF_FFFF));
      directed_steps.push_back(event_step(OP_COMPLETE, 0, 0, 0, 0, 0, 16'd3));
      directed_steps.push_back(write_step(ADDR_BOOT_MASK, 32'h0000_0000));
      directed_steps.push_back(event_step(OP_FRAME_END, 0, 0, 0, 0, 0, 0));

      foreach (directed_steps[k]) begin
         step = directed_steps[k];
         if (step.is_write) begin
            drain_events();
            csr_access(step.addr, step.wdata);
         end else begin
            send_event(step.ev, step.known, step.status);
         end
      end

      random_base = events_sent;
      while (events_sent - random_base < RANDOM_ITEMS) begin
         drain_events();
         case ($urandom_range(0, 5))
            0:       csr_access(ADDR_PLAN_LENGTH, 0);
            1:       csr_access(ADDR_PLAN_LENGTH, SLOTS);
            2:       csr_access(ADDR_PLAN_LENGTH, 31);
            3:       csr_access(ADDR_PLAN_LENGTH, 1);
            default: csr_access(ADDR_PLAN_LENGTH, $urandom_range(0, 31));
         endcase
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 3))
               0:       boot_value = 32'h0000_0000;
               1:       boot_value = 32'hFFFF_FFFF;
               default: boot_value = $urandom;
            endcase
            csr_access(ADDR_BOOT_MASK, boot_value);
         end
         no_idle     = ($urandom_range(0, 3) == 0);
         phase_start = events_sent;
         phase_goal  = $urandom_range(30, 80);
         while (events_sent - phase_start < phase_goal) begin
            if ($urandom_range(0, 3) != 0) begin
               run_frame();
            end else begin
               repeat ($urandom_range(1, 4)) send_event(noise_event());
            end
         end
      end

      drain_events();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0 && awaited_status.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/ppgp_pkg.sv
sv/ppgp_plan_mem.sv
sv/ppgp_seq.sv
sv/phase_aware_power_gate_planner.sv
tb/phase_aware_power_gate_planner_test.sv
